### src/bae_pkg.sv
// Shared types and constants for the binary arithmetic encoder.
// Used by every module of the block; depends on nothing.
package bae_pkg;

    localparam logic       OP_ENCODE     = 1'b0;
    localparam logic       OP_FLUSH      = 1'b1;
    localparam logic [7:0] PENDING_LIMIT = 8'd224;
    localparam int         BUF_DEPTH     = 64;
    localparam int         BUF_AW        = $clog2(BUF_DEPTH);
    localparam int         DIV_STEPS     = 64;
    localparam int         DIV_CW        = $clog2(DIV_STEPS);

    typedef struct packed {
        logic        op;
        logic        symbol_bit;
        logic [31:0] zero_weight;
        logic [31:0] total_weight;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       overflow;
    } t_out_item;

    // Queued job with weights already cleaned up.
    typedef struct packed {
        logic        op;
        logic        sym;
        logic [31:0] p0;
        logic [31:0] total;
    } t_job;

endpackage

### src/bae_front.sv
// Front end: accepts input transactions, cleans up the weights and queues jobs.
// Depends on bae_pkg.
module bae_front
    import bae_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    output logic     o_job_valid,
    output t_job     o_job,
    input  logic     i_job_pop
);

    t_job        r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        w_push;
    logic        w_pop;
    logic [31:0] w_total;
    t_job        w_job;

    assign o_in_stall  = (r_cnt == 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = i_job_pop && o_job_valid;

    // A zero total counts as one, and a zero weight above the total is clamped.
    always_comb begin
        w_total     = (i_in_item.total_weight == 32'd0) ? 32'd1 : i_in_item.total_weight;
        w_job.op    = i_in_item.op;
        w_job.sym   = i_in_item.symbol_bit;
        w_job.total = w_total;
        w_job.p0    = (i_in_item.zero_weight > w_total) ? w_total : i_in_item.zero_weight;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

### src/bae_div.sv
// Restoring divider, one quotient bit per cycle, for the interval split.
// Depends on bae_pkg.
module bae_div
    import bae_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [32:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [63:0]       r_num;
    logic [31:0]       r_rem;
    logic [31:0]       r_div;
    logic [32:0]       r_quot;
    logic [32:0]       w_rem_sh;
    logic              w_ge;
    logic [32:0]       w_rem_sub;

    assign o_done = r_done;
    assign o_quot = r_quot;

    always_comb begin
        w_rem_sh  = {r_rem, r_num[63]};
        w_ge      = (w_rem_sh >= {1'b0, r_div});
        w_rem_sub = w_rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_dividend;
            r_div  <= i_divisor;
            r_rem  <= 32'd0;
            r_quot <= 33'd0;
        end else if (r_busy) begin
            r_num  <= {r_num[62:0], 1'b0};
            r_rem  <= w_ge ? w_rem_sub[31:0] : w_rem_sh[31:0];
            r_quot <= {r_quot[31:0], w_ge};
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

### src/bae_back.sv
// Back end: interval split, renormalisation, bit packing and byte delivery.
// Depends on bae_pkg and bae_div.
module bae_back
    import bae_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_job_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_DSTART = 4'd2;
    localparam logic [3:0] S_DWAIT  = 4'd3;
    localparam logic [3:0] S_RENORM = 4'd4;
    localparam logic [3:0] S_EMIT   = 4'd5;
    localparam logic [3:0] S_PAD    = 4'd6;
    localparam logic [3:0] S_RD     = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]        r_state;
    logic [31:0]       r_low;
    logic [31:0]       r_high;
    logic [7:0]        r_pend;
    logic [7:0]        r_coll;
    logic [2:0]        r_bc;
    logic              r_ovf;
    logic              r_op;
    logic              r_sym;
    logic [31:0]       r_p0;
    logic [31:0]       r_total;
    logic [63:0]       r_prod;
    logic              r_cur;
    logic              r_opp;
    logic [7:0]        r_erem;
    logic [BUF_AW:0]   r_wcnt;
    logic [BUF_AW-1:0] r_rptr;
    logic              r_item_ovf;
    logic [7:0]        r_rd_data;
    logic [7:0]        r_mem [BUF_DEPTH];
    logic              r_ov;
    t_out_item         r_out;

    logic        w_div_done;
    logic [32:0] w_quot;
    logic [32:0] w_range;
    logic [63:0] w_prod;
    logic [33:0] w_split;
    logic [7:0]  w_coll_n;
    logic [7:0]  w_pad;
    logic        w_out_free;
    logic        w_last;

    assign o_job_pop   = (r_state == S_IDLE) && i_job_valid;
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    bae_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DSTART),
        .i_dividend (r_prod),
        .i_divisor  (r_total),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        w_range = {1'b0, r_high} - {1'b0, r_low} + 33'd1;
        // A full interval has range 2^32, whose product is the weight moved up.
        w_prod  = {(w_range[32] ? r_p0 : 32'd0), 32'd0}
                | (64'(w_range[31:0]) * 64'(r_p0));
        w_split = {2'b0, r_low} + {1'b0, w_quot};
        if (w_quot == 33'd0) begin
            w_split = {2'b0, r_low} + 34'd1;
        end
        if (w_split > {2'b0, r_high}) begin
            w_split = {2'b0, r_high};
        end
        w_coll_n   = {r_coll[6:0], r_cur};
        w_pad      = r_coll << (~r_bc + 3'd1);
        w_out_free = !r_ov || !i_out_stall;
        w_last     = (r_rptr == BUF_AW'(r_wcnt - 1'b1));
    end

    always_ff @(posedge i_clk) begin
        // Byte buffer and its registered read port.
        if (r_state == S_EMIT && r_bc == 3'd7) begin
            r_mem[r_wcnt[BUF_AW-1:0]] <= w_coll_n;
        end else if (r_state == S_PAD && r_bc != 3'd0) begin
            r_mem[r_wcnt[BUF_AW-1:0]] <= w_pad;
        end
        if (r_state == S_RD) begin
            r_rd_data <= r_mem[r_rptr];
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out.out_byte    <= r_rd_data;
            r_out.last_of_run <= w_last;
            r_out.overflow    <= r_item_ovf;
        end
        if (r_state == S_IDLE && i_job_valid) begin
            r_p0    <= i_job.p0;
            r_total <= i_job.total;
            r_sym   <= i_job.sym;
        end
        if (r_state == S_MUL) begin
            r_prod <= w_prod;
        end

        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_low      <= 32'd0;
            r_high     <= 32'hFFFF_FFFF;
            r_pend     <= 8'd0;
            r_coll     <= 8'd0;
            r_bc       <= 3'd0;
            r_ovf      <= 1'b0;
            r_op       <= OP_ENCODE;
            r_cur      <= 1'b0;
            r_opp      <= 1'b0;
            r_erem     <= 8'd0;
            r_wcnt     <= '0;
            r_rptr     <= '0;
            r_item_ovf <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (r_state == S_OUT && w_out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_op <= i_job.op;
                        if (i_job.op == OP_FLUSH) begin
                            r_cur   <= r_low[30];
                            r_opp   <= ~r_low[30];
                            r_erem  <= r_pend + 8'd1;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_div_done) begin
                        if (r_sym == 1'b0) begin
                            r_high <= 32'(w_split - 34'd1);
                        end else begin
                            r_low <= w_split[31:0];
                        end
                        r_state <= S_RENORM;
                    end
                end
                S_RENORM: begin
                    if (r_high[31] == r_low[31]) begin
                        r_cur   <= r_high[31];
                        r_opp   <= ~r_high[31];
                        r_erem  <= r_pend;
                        r_pend  <= 8'd0;
                        r_low   <= {r_low[30:0], 1'b0};
                        r_high  <= {r_high[30:0], 1'b1};
                        r_state <= S_EMIT;
                    end else if (r_low[30] && !r_high[30]) begin
                        // Straddle of the middle: defer one opposite bit, or flag overflow at the limit.
                        if (r_pend >= PENDING_LIMIT) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_pend <= r_pend + 8'd1;
                        end
                        r_low  <= {1'b0, r_low[29:0], 1'b0};
                        r_high <= {1'b1, r_high[29:0], 1'b1};
                    end else begin
                        r_item_ovf <= r_ovf;
                        r_rptr     <= '0;
                        r_state    <= (r_wcnt == '0) ? S_IDLE : S_RD;
                    end
                end
                S_EMIT: begin
                    if (r_bc == 3'd7) begin
                        r_coll <= 8'd0;
                        r_wcnt <= r_wcnt + 1'b1;
                    end else begin
                        r_coll <= w_coll_n;
                    end
                    r_bc  <= r_bc + 3'd1;
                    r_cur <= r_opp;
                    if (r_erem == 8'd0) begin
                        r_state <= (r_op == OP_FLUSH) ? S_PAD : S_RENORM;
                    end else begin
                        r_erem <= r_erem - 8'd1;
                    end
                end
                S_PAD: begin
                    // End of stream: the flag goes out with the bytes, then all
                    // coder state returns to its reset value.
                    r_item_ovf <= r_ovf;
                    r_rptr     <= '0;
                    if (r_bc != 3'd0) begin
                        r_wcnt  <= r_wcnt + 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_state <= (r_wcnt == '0) ? S_IDLE : S_RD;
                    end
                    r_low  <= 32'd0;
                    r_high <= 32'hFFFF_FFFF;
                    r_pend <= 8'd0;
                    r_coll <= 8'd0;
                    r_bc   <= 3'd0;
                    r_ovf  <= 1'b0;
                end
                S_RD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        if (w_last) begin
                            r_wcnt  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_rptr  <= r_rptr + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### src/binary_arithmetic_encoder_core.sv
// Top level of the binary arithmetic encoder: front queue plus coding back end.
// Depends on bae_pkg, bae_front and bae_back.
//
// Each encode transaction runs the 64-step bit-serial divider that computes
// the split, then renormalises and emits its bits. Bytes caused by a
// transaction are held in a 64-byte buffer and delivered once the transaction
// is fully coded, each byte read from the buffer and then registered at the
// output, so the overflow flag on each byte is the final one. A
// two-entry queue in front lets new transactions be taken while the back end
// is busy. The output register holds a byte while the receiver stalls, and the
// back end waits for it to empty before handing over the next byte.
module binary_arithmetic_encoder_core
    import bae_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic w_job_valid;
    t_job w_job;
    logic w_job_pop;

    bae_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    bae_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

### test/tb.sv
// Self-checking testbench for binary_arithmetic_encoder_core.
// Depends on bae_pkg and the encoder RTL. A built-in model predicts all but typed rows' bytes.
module tb;
    import bae_pkg::*;

    localparam int IDLE_LIMIT = 50000;
    localparam int HOLD_CYCLES = 600;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    binary_arithmetic_encoder_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Coder state as the model keeps it.
    logic [31:0] enc_lo;
    logic [31:0] enc_hi;
    logic [7:0]  pend_cnt;
    logic [7:0]  coll_bits;
    int unsigned coll_n;
    logic        ovf_seen;
    logic [7:0]  run_bytes[$];
    t_out_item   expected_bytes[$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic long_hold = 1'b0;
    bit hold_go = 0;
    int idle_cycles = 0;

    typedef struct {
        t_in_item   it;
        bit         typed;
        logic [7:0] exp_byte;
    } t_row;

    function automatic void clear_coder();
        enc_lo    = 32'h0;
        enc_hi    = 32'hFFFF_FFFF;
        pend_cnt  = 8'd0;
        coll_bits = 8'd0;
        coll_n    = 0;
        ovf_seen  = 1'b0;
    endfunction

    function automatic void shift_bit(logic b);
        coll_bits = {coll_bits[6:0], b};
        coll_n++;
        if (coll_n == 8) begin
            run_bytes.push_back(coll_bits);
            coll_bits = 8'd0;
            coll_n    = 0;
        end
    endfunction

    function automatic void emit_run(logic b, int unsigned n);
        shift_bit(b);
        for (int unsigned i = 0; i < n; i++) shift_bit(~b);
    endfunction

    // Advances the coder by one transaction and, when record is set, queues the bytes it yields.
    function automatic void code_item(t_in_item it, bit record);
        logic [63:0] p0;
        logic [63:0] tot;
        logic [63:0] rng;
        logic [63:0] split;
        logic        ovf_now;
        t_out_item   r;
        run_bytes.delete();
        if (it.op == OP_ENCODE) begin
            tot = {32'd0, it.total_weight};
            if (tot == 0) tot = 1;
            p0 = {32'd0, it.zero_weight};
            if (p0 > tot) p0 = tot;
            rng   = {32'd0, enc_hi} - {32'd0, enc_lo} + 64'd1;
            split = {32'd0, enc_lo} + (rng * p0) / tot;
            if (split <= {32'd0, enc_lo}) split = {32'd0, enc_lo} + 64'd1;
            if (split > {32'd0, enc_hi}) split = {32'd0, enc_hi};
            if (it.symbol_bit == 1'b0) enc_hi = split[31:0] - 32'd1;
            else enc_lo = split[31:0];
            while (1) begin
                if (enc_hi[31] == enc_lo[31]) begin
                    emit_run(enc_hi[31], pend_cnt);
                    pend_cnt = 8'd0;
                    enc_lo   = {enc_lo[30:0], 1'b0};
                    enc_hi   = {enc_hi[30:0], 1'b1};
                end else if (enc_lo[30] && !enc_hi[30]) begin
                    if (pend_cnt >= PENDING_LIMIT) ovf_seen = 1'b1;
                    else pend_cnt++;
                    enc_lo = {1'b0, enc_lo[29:0], 1'b0};
                    enc_hi = {1'b1, enc_hi[29:0], 1'b1};
                end else begin
                    break;
                end
            end
            ovf_now = ovf_seen;
        end else begin
            emit_run(enc_lo[30], int'(pend_cnt) + 1);
            if (coll_n > 0) run_bytes.push_back(coll_bits << (8 - coll_n));
            ovf_now = ovf_seen;
            clear_coder();
        end
        if (record) begin
            foreach (run_bytes[k]) begin
                r.out_byte    = run_bytes[k];
                r.last_of_run = (k == run_bytes.size() - 1);
                r.overflow    = ovf_now;
                expected_bytes.push_back(r);
            end
        end
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        it.op           = ($urandom_range(99) < 8) ? OP_FLUSH : OP_ENCODE;
        it.symbol_bit   = 1'($urandom_range(1));
        it.zero_weight  = $urandom;
        case ($urandom_range(3))
            0: it.total_weight = 32'd0;
            1: it.total_weight = $urandom_range(1, 16);
            default: it.total_weight = $urandom;
        endcase
        return it;
    endfunction

    // Picks weights that pull the interval edge towards the middle, so that
    // straddles pile up pending bits and eventually reach the limit.
    function automatic t_in_item squeeze_item(logic sym);
        t_in_item    it;
        logic [63:0] target;
        logic [63:0] rng;
        target = sym ? {32'd0, 32'h7FFF_FF00 | $urandom_range(255)}
                     : {32'd0, 32'h8000_0100 | $urandom_range(255)};
        if (target <= {32'd0, enc_lo} || target > {32'd0, enc_hi}) return random_item();
        rng             = {32'd0, enc_hi} - {32'd0, enc_lo} + 64'd1;
        it.op           = OP_ENCODE;
        it.symbol_bit   = sym;
        it.total_weight = 32'h0100_0000;
        it.zero_weight  = 32'((((target - {32'd0, enc_lo}) << 24) / rng));
        return it;
    endfunction

    task automatic send(t_in_item it, bit typed, logic [7:0] exp_byte);
        t_out_item r;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        code_item(it, !typed);
        if (typed) begin
            r.out_byte    = exp_byte;
            r.last_of_run = 1'b1;
            r.overflow    = 1'b0;
            expected_bytes.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (long_hold) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        wait (hold_go);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte %h", $time, out_item);
                errors++;
            end else begin
                e = expected_bytes.pop_front();
                if (out_item.out_byte !== e.out_byte || out_item.last_of_run !== e.last_of_run
                    || out_item.overflow !== e.overflow) begin
                    $display("%0t: expected byte %h last %b ovf %b, got byte %h last %b ovf %b",
                             $time, e.out_byte, e.last_of_run, e.overflow,
                             out_item.out_byte, out_item.last_of_run, out_item.overflow);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either side ends the run.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        t_row rows[15];
        int   send_pct[4];
        int   recv_pct[4];
        int   sent;
        int   pairs;
        rows = '{
            '{'{OP_FLUSH,  1'b0, 32'd0,          32'd1},          1'b1, 8'h40},
            '{'{OP_FLUSH,  1'b1, 32'hFFFF_FFFF,  32'hFFFF_FFFF},  1'b1, 8'h40},
            '{'{OP_ENCODE, 1'b0, 32'd0,          32'd0},          1'b0, 8'h00},
            '{'{OP_ENCODE, 1'b1, 32'hFFFF_FFFF,  32'd5},          1'b0, 8'h00},
            '{'{OP_FLUSH,  1'b0, 32'd0,          32'd1},          1'b0, 8'h00},
            '{'{OP_ENCODE, 1'b0, 32'hFFFF_FFFF,  32'hFFFF_FFFF},  1'b0, 8'h00},
            '{'{OP_FLUSH,  1'b0, 32'd0,          32'd1},          1'b0, 8'h00},
            '{'{OP_ENCODE, 1'b1, 32'hFFFF_FFFF,  32'hFFFF_FFFF},  1'b0, 8'h00},
            '{'{OP_ENCODE, 1'b0, 32'd0,          32'hFFFF_FFFF},  1'b0, 8'h00},
            '{'{OP_ENCODE, 1'b1, 32'd0,          32'd1},          1'b0, 8'h00},
            '{'{OP_ENCODE, 1'b0, 32'd1,          32'd2},          1'b0, 8'h00},
            '{'{OP_ENCODE, 1'b1, 32'h8000_0000,  32'hFFFF_FFFF},  1'b0, 8'h00},
            '{'{OP_ENCODE, 1'b0, 32'h7FFF_FFFF,  32'h8000_0000},  1'b0, 8'h00},
            '{'{OP_FLUSH,  1'b0, 32'd0,          32'd1},          1'b0, 8'h00},
            '{'{OP_FLUSH,  1'b0, 32'd0,          32'd1},          1'b1, 8'h40}
        };
        send_pct = '{0, 57, 0, 34};
        recv_pct = '{0, 0, 57, 34};
        clear_coder();
        i_rst_n   <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].exp_byte);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            if (ph == 0) hold_go = 1;
            sent = 0;
            while (sent < 45) begin
                if ($urandom_range(99) < 60) begin
                    // Well-formed squeeze run with random noise, then often a flush.
                    pairs = $urandom_range(2, 14);
                    for (int p = 0; p < pairs; p++) begin
                        send(squeeze_item(1'b1), 0, 8'h00);
                        send(squeeze_item(1'b0), 0, 8'h00);
                        if ($urandom_range(9) == 0) begin
                            send(random_item(), 0, 8'h00);
                            sent++;
                        end
                    end
                    sent += 2 * pairs;
                    if ($urandom_range(3) != 0) begin
                        send('{OP_FLUSH, 1'($urandom_range(1)), 32'($urandom),
                               32'($urandom)}, 0, 8'h00);
                        sent++;
                    end
                end else begin
                    repeat (5) send(random_item(), 0, 8'h00);
                    sent += 5;
                end
            end
        end
        send('{OP_FLUSH, 1'b0, 32'd0, 32'd1}, 0, 8'h00);
        in_valid <= 1'b0;

        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
